// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by sine_polynomial_approx.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg
// Constants of the fixed-point sine pipeline (Q2.30 internal format).
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int unsigned LAT = 13;          // number of pipeline stages

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [29:0] C1_Q30 = 30'd1073741609;
  localparam logic [27:0] C3_Q30 = 28'd178956996;
  localparam logic [23:0] C5_Q30 = 24'd8947302;
  localparam logic [17:0] C7_Q30 = 18'd210323;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // quotient estimate: floor(mag * RECIP >> RECIP_SHIFT) is the true
  // quotient of (mag << 14) / 2pi or one less
  localparam int unsigned RECIP_SHIFT = 45;
  localparam logic [63:0] RECIP_FULL  = (64'd1 << (RECIP_SHIFT + 14)) / 64'(TWO_PI_Q30);
  localparam logic [26:0] RECIP_Q     = RECIP_FULL[26:0];

endpackage

// ----- hw/rtl/sine_polynomial_approx.sv -----
// ----------------------------------------------------------------------------
// sine_polynomial_approx
// Pipelined fixed-point sine: range reduction mod 2pi, quadrant fold and a
// degree-7 odd polynomial by Horner's rule. Q16.16 in, Q1.16 out.
// ----------------------------------------------------------------------------
//
//  channel | ports                 | handshake
//  --------+-----------------------+-------------------------------------
//  input   | in_angle   [31:0] s   | taken when start && !busy
//  result  | out_sine   [17:0] s   | out_valid, one cycle, no back-pressure
//
//  One word enters per cycle; busy never rises. The pipeline has 13 register
//  stages: seven multipliers, each in a stage of its own, plus sign/magnitude,
//  remainder, correction, two folds and rounding. Reset (synchronous, rst_n
//  low) clears the valid bits only; words in flight are dropped. The receiver
//  cannot stall, so nothing is ever held.
//
`include "assert_macros.svh"

module sine_polynomial_approx
  import spa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  output logic signed [17:0] out_sine
);

  logic [LAT-1:0] vld_r;

  // stage payload
  logic [31:0] mag1_r;  logic neg1_r;
  logic [31:0] mag2_r;  logic neg2_r;  logic [12:0] quo2_r;
  logic [45:0] num3_r;  logic neg3_r;  logic [45:0] prod3_r;
  logic [33:0] rem4_r;  logic neg4_r;
  logic [32:0] rem5_r;  logic neg5_r;
  logic [31:0] rem6_r;  logic neg6_r;
  logic [30:0] x7_r;    logic neg7_r;
  logic [30:0] x8_r;    logic neg8_r;  logic [31:0] xsq8_r;
  logic [30:0] x9_r;    logic neg9_r;  logic [31:0] xsq9_r;  logic [23:0] t9_r;
  logic [30:0] x10_r;   logic neg10_r; logic [31:0] xsq10_r; logic [27:0] t10_r;
  logic [30:0] x11_r;   logic neg11_r; logic [29:0] t11_r;
  logic [30:0] s12_r;   logic neg12_r;
  logic signed [17:0] sine_r;

  logic [31:0] mag_nxt;
  logic [58:0] qprod;
  logic [33:0] rem4_nxt;
  logic [32:0] rem5_nxt;
  logic [61:0] xsq_prod;
  logic [49:0] p9;
  logic [55:0] p10;
  logic [59:0] p11;
  logic [60:0] p12;
  logic [31:0] s_rnd;
  logic [16:0] q_sat;

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];
  assign out_sine  = sine_r;

  // magnitude; -2^31 wraps to 2^31, which is the right unsigned value
  assign mag_nxt  = in_angle[31] ? (~in_angle + 32'd1) : in_angle;
  assign qprod    = 59'(mag1_r) * 59'(RECIP_Q);
  assign rem4_nxt = 34'(num3_r - prod3_r);
  assign rem5_nxt = (rem4_r >= 34'(TWO_PI_Q30)) ? 33'(rem4_r - 34'(TWO_PI_Q30))
                                                : rem4_r[32:0];
  assign xsq_prod = 62'(x7_r) * 62'(x7_r);
  assign p9       = 50'(C7_Q30) * 50'(xsq8_r);
  assign p10      = 56'(t9_r) * 56'(xsq9_r);
  assign p11      = 60'(t10_r) * 60'(xsq10_r);
  assign p12      = 61'(x11_r) * 61'(t11_r);
  assign s_rnd    = (32'(s12_r) + 32'd8192) >> 14;
  assign q_sat    = (s_rnd > 32'(ONE_Q16)) ? ONE_Q16 : s_rnd[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    // s1: sign and magnitude
    mag1_r  <= mag_nxt;
    neg1_r  <= in_angle[31];
    // s2: quotient estimate by constant reciprocal
    mag2_r  <= mag1_r;
    neg2_r  <= neg1_r;
    quo2_r  <= qprod[57:45];
    // s3: quotient times 2pi
    num3_r  <= {mag2_r, 14'd0};
    neg3_r  <= neg2_r;
    prod3_r <= 46'(quo2_r) * 46'(TWO_PI_Q30);
    // s4: raw remainder, below 2*2pi
    rem4_r  <= rem4_nxt;
    neg4_r  <= neg3_r;
    // s5: one correction step
    rem5_r  <= rem5_nxt;
    neg5_r  <= neg4_r;
    // s6: fold upper half onto [0, pi]
    if (rem5_r > 33'(PI_Q30)) begin
      rem6_r <= 32'(rem5_r - 33'(PI_Q30));
      neg6_r <= ~neg5_r;
    end else begin
      rem6_r <= rem5_r[31:0];
      neg6_r <= neg5_r;
    end
    // s7: mirror into [0, pi/2]
    x7_r    <= (rem6_r > 32'(HALF_PI_Q30)) ? 31'(PI_Q30 - rem6_r) : rem6_r[30:0];
    neg7_r  <= neg6_r;
    // s8: x^2
    x8_r    <= x7_r;
    neg8_r  <= neg7_r;
    xsq8_r  <= xsq_prod[61:30];
    // s9..s11: Horner steps, all terms stay nonnegative
    x9_r    <= x8_r;
    neg9_r  <= neg8_r;
    xsq9_r  <= xsq8_r;
    t9_r    <= 24'(C5_Q30 - 24'(p9[49:30]));
    x10_r   <= x9_r;
    neg10_r <= neg9_r;
    xsq10_r <= xsq9_r;
    t10_r   <= 28'(C3_Q30 - 28'(p10[55:30]));
    x11_r   <= x10_r;
    neg11_r <= neg10_r;
    t11_r   <= 30'(C1_Q30 - 30'(p11[59:30]));
    // s12: final product
    s12_r   <= p12[60:30];
    neg12_r <= neg11_r;
    // s13: round to Q1.16, saturate, apply sign
    sine_r  <= (neg12_r && q_sat != 17'd0) ? -$signed({1'b0, q_sat})
                                           : $signed({1'b0, q_sat});
  end

  `ASSERT_CLK(a_latency, start |-> ##13 out_valid, "result strobe missing after latency")
  `ASSERT_CLK(a_zero_in, (start && in_angle == 32'sd0) |-> ##13 (out_sine == 18'sd0),
    "zero angle gave nonzero sine")
  `ASSERT_CLK(a_range, out_valid |-> ($signed(out_sine) <= 18'sd65536 &&
    $signed(out_sine) >= -18'sd65536), "sine out of range")
  `ASSERT_ALWAYS(a_flush, !rst_n |=> !out_valid, "strobe after reset")

endmodule

// ----- bench/sine_polynomial_approx_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sine_polynomial_approx_tb
// Self-checking bench for the pipelined fixed-point sine. Directed table angles
// run first, then random angles over phases with different amounts of sender
// idling. Sines are checked in order against a bit-true model or a typed table value.
// ----------------------------------------------------------------------------
module sine_polynomial_approx_tb
  import spa_pkg::*;
();

  localparam int unsigned WORDS_PER_PHASE = 300;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned NUM_ROWS        = 20;

  // Q2.30 constants of the sine datapath
  localparam logic [63:0] K_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] K_PI      = 64'd3373259426;
  localparam logic [63:0] K_HALF_PI = 64'd1686629713;
  localparam logic [63:0] K_C1      = 64'd1073741609;
  localparam logic [63:0] K_C3      = 64'd178956996;
  localparam logic [63:0] K_C5      = 64'd8947302;
  localparam logic [63:0] K_C7      = 64'd210323;

  // Q16.16 angles that hit the fold points
  localparam logic [31:0] A_HALF_PI = 32'd102944;
  localparam logic [31:0] A_PI      = 32'd205887;
  // |angle| << 14 is exactly 4096 turns of 2pi
  localparam logic [31:0] A_TURNS   = 32'd1686629713;

  typedef struct {
    logic [31:0] angle;
    bit          typed;
    logic [17:0] sine;
  } angle_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic signed [31:0] in_angle = '0;
  logic               busy;
  logic               out_valid;
  logic signed [17:0] out_sine;

  logic [17:0] sine_queue[$];
  int unsigned errors = 0;
  int unsigned sines_checked = 0;
  int unsigned negative_sines = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;

  angle_row_t angle_rows [NUM_ROWS] = '{
    '{32'd0,          1'b1, 18'd0},
    '{32'd1,          1'b0, 18'd0},
    '{32'hFFFF_FFFF,  1'b0, 18'd0},
    '{32'h7FFF_FFFF,  1'b0, 18'd0},
    '{32'h8000_0000,  1'b0, 18'd0},
    '{32'h0001_0000,  1'b0, 18'd0},
    '{A_HALF_PI,      1'b0, 18'd0},
    '{-A_HALF_PI,     1'b0, 18'd0},
    '{A_PI,           1'b0, 18'd0},
    '{A_PI + 32'd1,   1'b0, 18'd0},
    '{-A_PI,          1'b0, 18'd0},
    '{32'd308831,     1'b0, 18'd0},
    '{32'd411775,     1'b0, 18'd0},
    '{A_TURNS,        1'b1, 18'd0},
    '{-A_TURNS,       1'b1, 18'd0},
    '{A_TURNS + 32'd1, 1'b0, 18'd0},
    '{-(A_TURNS + 32'd1), 1'b0, 18'd0},
    '{32'h5555_5555,  1'b0, 18'd0},
    '{32'hAAAA_AAAA,  1'b0, 18'd0},
    '{32'h0000_FFFF,  1'b0, 18'd0}
  };

  sine_polynomial_approx u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_angle (in_angle),
    .out_valid(out_valid),
    .out_sine (out_sine)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [17:0] expected_sine(input logic [31:0] a);
    logic        neg;
    logic [63:0] mag, r, x2, t, s, q;
    if (a == 32'd0) return 18'd0;
    neg = a[31];
    mag = neg ? (64'h1_0000_0000 - 64'(a)) : 64'(a);
    r = (mag << 14) % K_TWO_PI;
    if (r > K_PI) begin
      r = r - K_PI;
      neg = ~neg;
    end
    if (r > K_HALF_PI) r = K_PI - r;
    x2 = q30_mul(r, r);
    t = K_C5 - q30_mul(K_C7, x2);
    t = K_C3 - q30_mul(t, x2);
    t = K_C1 - q30_mul(t, x2);
    s = q30_mul(r, t);
    q = (s + 64'd8192) >> 14;
    if (q > 64'd65536) q = 64'd65536;
    if (neg && q != 64'd0) return 18'(64'h40000 - q);
    return q[17:0];
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // holds the word on the port until it is taken; expectation queued on accept
  task automatic send_angle(input logic [31:0] a, input logic [17:0] want);
    start    <= 1'b1;
    in_angle <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    sine_queue.push_back(want);
    words_sent++;
  endtask

  task automatic idle_gap(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (sine_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_angle();
    logic [31:0] a;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // within a couple of turns, where the folds matter most
      a = $urandom_range(823550);
    end else if (pick < 60) begin
      a = $urandom_range(40) * A_HALF_PI + $urandom_range(8) - 32'd4;
    end else if (pick < 70) begin
      a = A_TURNS + $urandom_range(64) - 32'd32;
    end else if (pick < 75) begin
      a = 32'h7FFF_FFFF - $urandom_range(64);
    end else begin
      a = $urandom;
    end
    if (pick < 75 && $urandom_range(1)) a = -a;
    return a;
  endfunction

  // scoreboard and watchdog
  always @(posedge clk) begin
    logic [17:0] want;
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_valid) begin
      if (sine_queue.size() == 0) begin
        flag_error($sformatf("unexpected sine word %h", out_sine));
      end else begin
        want = sine_queue.pop_front();
        sines_checked++;
        if (want[17]) negative_sines++;
        if (out_sine !== want)
          flag_error($sformatf("sine mismatch: expected %h, got %h", want, out_sine));
      end
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
      $display("sine_polynomial_approx_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_idle [4];
    logic [31:0] a;
    phase_idle = '{0, 55, 17, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (angle_rows[i]) begin
      idle_gap(20);
      send_angle(angle_rows[i].angle,
                 angle_rows[i].typed ? angle_rows[i].sine
                                     : expected_sine(angle_rows[i].angle));
    end
    drain_pipe();

    foreach (phase_idle[p]) begin
      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
        idle_gap(phase_idle[p]);
        a = random_angle();
        send_angle(a, expected_sine(a));
      end
      // sender holds off until the pipe is empty
      drain_pipe();
    end

    repeat (LAT + 8) @(posedge clk);
    if (sine_queue.size() != 0)
      flag_error($sformatf("%0d sine words never arrived", sine_queue.size()));

    $display("Sent %0d angles (%0d from the directed table) under 0/55/17%% sender idling.",
             words_sent, NUM_ROWS);
    $display("Checked %0d sines, %0d of them negative; %0d errors.",
             sines_checked, negative_sines, errors);
    if (errors == 0) begin
      $display("sine_polynomial_approx_tb passed");
    end else begin
      $display("sine_polynomial_approx_tb failed");
    end
    $finish;
  end

endmodule
